>>> src/sbp_pkg.sv
// Shared types, constants and arithmetic helpers for the sphere-in-box physics step.
package sbp_pkg;

    typedef logic signed [31:0] word_t;

    localparam int unsigned RADIUS_W = 22;
    localparam int unsigned START_W  = 23;
    localparam int unsigned TSTEP_W  = 17;
    localparam int unsigned SQ_W     = 28;
    localparam int unsigned MASS_W   = 34;

    // Box walls in Q16.16
    localparam word_t BOX_LO_XZ = -32'sd3276800;
    localparam word_t BOX_HI_XZ = 32'sd3276800;
    localparam word_t BOX_LO_Y  = 32'sd0;
    localparam word_t BOX_HI_Y  = 32'sd6553600;

    // 0.9 in Q0.16
    localparam logic [15:0] FLOOR_DAMP = 16'd58982;

    localparam logic [1:0] MODE_ADD     = 2'd0;
    localparam logic [1:0] MODE_STEP    = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    localparam logic [1:0] CFG_RADIUS  = 2'd0;
    localparam logic [1:0] CFG_START_X = 2'd1;
    localparam logic [1:0] CFG_START_Y = 2'd2;
    localparam logic [1:0] CFG_START_Z = 2'd3;

    localparam logic [4:0] DIV_LAST = 5'd31;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MASS_SQ,
        ST_MASS_CUBE,
        ST_DIV_LOAD,
        ST_DIVIDE,
        ST_MUL_ACC,
        ST_ADD_VEL,
        ST_MUL_VEL,
        ST_ADD_POS,
        ST_MERGE_LOAD,
        ST_BOUNCE_XY,
        ST_DAMP,
        ST_BOUNCE_Z,
        ST_COMMIT,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic mul_acc;
        logic mul_vel;
        logic add_vel;
        logic add_pos;
    } lane_ctrl_t;

    typedef struct packed {
        logic load;
        logic bounce_xy;
        logic damp;
        logic bounce_z;
    } merge_ctrl_t;

    typedef struct packed {
        word_t pos;
        word_t vel;
        logic  hit_lo;
        logic  hit_hi;
    } bounce_t;

    // Clamp a 34-bit signed value to the signed 32-bit range
    function automatic word_t sat32(input logic signed [33:0] v);
        word_t r;
        if (!v[33] && (v[32] || v[31])) begin
            r = 32'sh7FFF_FFFF;
        end else if (v[33] && !(v[32] && v[31])) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] abs32(input word_t v);
        logic [31:0] r;
        r = v[31] ? (~v + 32'd1) : v;
        return r;
    endfunction

    // Give a 33-bit magnitude its sign, then saturate
    function automatic word_t apply_sign(input logic [32:0] mag, input logic neg);
        logic signed [33:0] s;
        s = $signed({1'b0, mag});
        if (neg) begin
            s = -s;
        end
        return sat32(s);
    endfunction

    function automatic word_t add_sat(input word_t a, input word_t b);
        logic signed [33:0] s;
        s = $signed({{2{a[31]}}, a}) + $signed({{2{b[31]}}, b});
        return sat32(s);
    endfunction

    // Reverse and halve, truncating toward zero
    function automatic word_t halve_reverse(input word_t v);
        logic [31:0] m;
        m = abs32(v) >> 1;
        return v[31] ? $signed(m) : -$signed(m);
    endfunction

endpackage

>>> src/sphere_box_physics_step.sv
// Top level: one sphere bouncing in a fixed box, stepped one item at a time in Q16.16.
//
// Usage: items enter on in_valid/in_ready with a mode and a force vector;
// each item yields one result on out_valid/out_ready holding position,
// velocity and the walls bounced. Mode 0 accumulates force, mode 1 makes one
// integration step with collision, mode 2 restarts at the start position,
// mode 3 only reports the state.
// A step item squares and cubes the radius for the mass, runs the restoring
// divide of force over mass in the three axis lanes, makes two multiply/add
// pairs per lane and takes the merge stage through its load, x/y bounce,
// floor damping and z bounce; other modes go straight to their result.
// One item at a time: in_ready rises the cycle the result is posted.
// The output register frees the input side: a new item is taken while the
// last result still waits. If the receiver stalls, the block finishes the
// next item and holds in its final state until the output register is free.
// Reset clears position, velocity and force, sets radius to 1.0 and the
// start position to the origin. Configuration writes land on cfg_we and
// should only be issued while the block is idle.
module sphere_box_physics_step (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [sbp_pkg::START_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          mode,
    input  logic signed [31:0]                  force_x,
    input  logic signed [31:0]                  force_y,
    input  logic signed [31:0]                  force_z,
    input  logic [sbp_pkg::TSTEP_W-1:0]         time_step,
    output logic                                out_valid,
    input  logic                                out_ready,
    output sbp_pkg::word_t                      pos_x,
    output sbp_pkg::word_t                      pos_y,
    output sbp_pkg::word_t                      pos_z,
    output sbp_pkg::word_t                      vel_x,
    output sbp_pkg::word_t                      vel_y,
    output sbp_pkg::word_t                      vel_z,
    output logic [5:0]                          wall_hits
);
    import sbp_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Configuration
    logic [RADIUS_W-1:0]       radius_reg;
    logic signed [START_W-1:0] start_x_reg;
    logic [START_W-1:0]        start_y_reg;
    logic signed [START_W-1:0] start_z_reg;

    // Sphere state
    word_t      pos_reg  [3];
    word_t      vel_reg  [3];
    word_t      facc_reg [3];
    logic [5:0] hits_reg;

    // Item being worked on
    word_t               force_reg [3];
    logic [TSTEP_W-1:0]  tstep_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [MASS_W-1:0]   mass_reg;
    logic [4:0]          div_cnt_reg;

    // Output register
    logic       out_valid_reg;
    word_t      out_pos_reg [3];
    word_t      out_vel_reg [3];
    logic [5:0] out_hits_reg;

    logic        accept;
    logic        out_free;
    lane_ctrl_t  lane_ctrl;
    merge_ctrl_t merge_ctrl;
    word_t       force_vec [3];
    word_t       lane_vel [3];
    word_t       lane_pos [3];
    word_t       merge_pos [3];
    word_t       merge_vel [3];
    logic [5:0]  merge_hits;
    logic [43:0] sq_full;
    logic [49:0] cube_full;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign force_vec[0] = force_x;
    assign force_vec[1] = force_y;
    assign force_vec[2] = force_z;

    assign sq_full   = {22'd0, radius_reg} * {22'd0, radius_reg};
    assign cube_full = {22'd0, sq_reg} * {28'd0, radius_reg};

    // Sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (mode == MODE_STEP) ? ST_MASS_SQ : ST_WRITE;
                end
            end
            ST_MASS_SQ:    state_next = ST_MASS_CUBE;
            ST_MASS_CUBE:  state_next = ST_DIV_LOAD;
            ST_DIV_LOAD:   state_next = ST_DIVIDE;
            ST_DIVIDE:
            begin
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = ST_MUL_ACC;
                end
            end
            ST_MUL_ACC:    state_next = ST_ADD_VEL;
            ST_ADD_VEL:    state_next = ST_MUL_VEL;
            ST_MUL_VEL:    state_next = ST_ADD_POS;
            ST_ADD_POS:    state_next = ST_MERGE_LOAD;
            ST_MERGE_LOAD: state_next = ST_BOUNCE_XY;
            ST_BOUNCE_XY:  state_next = ST_DAMP;
            ST_DAMP:       state_next = ST_BOUNCE_Z;
            ST_BOUNCE_Z:   state_next = ST_COMMIT;
            ST_COMMIT:     state_next = ST_WRITE;
            ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // Sequencer: in_ready and per-state strobes to the lanes and the merge stage
    always_comb
    begin
        in_ready   = 1'b0;
        lane_ctrl  = '0;
        merge_ctrl = '0;
        case (state_reg)
            ST_IDLE:       in_ready             = 1'b1;
            ST_DIV_LOAD:   lane_ctrl.load       = 1'b1;
            ST_DIVIDE:     lane_ctrl.div_step   = 1'b1;
            ST_MUL_ACC:    lane_ctrl.mul_acc    = 1'b1;
            ST_ADD_VEL:    lane_ctrl.add_vel    = 1'b1;
            ST_MUL_VEL:    lane_ctrl.mul_vel    = 1'b1;
            ST_ADD_POS:    lane_ctrl.add_pos    = 1'b1;
            ST_MERGE_LOAD: merge_ctrl.load      = 1'b1;
            ST_BOUNCE_XY:  merge_ctrl.bounce_xy = 1'b1;
            ST_DAMP:       merge_ctrl.damp      = 1'b1;
            ST_BOUNCE_Z:   merge_ctrl.bounce_z  = 1'b1;
            default:       in_ready             = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DIV_LOAD)
            begin
                div_cnt_reg <= 5'd0;
            end
            else if (state_reg == ST_DIVIDE)
            begin
                div_cnt_reg <= div_cnt_reg + 5'd1;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= RADIUS_W'(65536);
            start_x_reg <= '0;
            start_y_reg <= '0;
            start_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RADIUS:  radius_reg  <= cfg_data[RADIUS_W-1:0];
                CFG_START_X: start_x_reg <= cfg_data;
                CFG_START_Y: start_y_reg <= cfg_data;
                CFG_START_Z: start_z_reg <= cfg_data;
                default:     radius_reg  <= radius_reg;
            endcase
        end
    end

    // Sphere state: add force and restart on acceptance, commit after a step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i]  <= '0;
                vel_reg[i]  <= '0;
                facc_reg[i] <= '0;
            end
            hits_reg <= 6'd0;
        end
        else if (accept)
        begin
            hits_reg <= 6'd0;
            case (mode)
                MODE_ADD:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        facc_reg[i] <= add_sat(facc_reg[i], force_vec[i]);
                    end
                end
                MODE_RESTART:
                begin
                    pos_reg[0] <= {{(32-START_W){start_x_reg[START_W-1]}}, start_x_reg};
                    pos_reg[1] <= {{(32-START_W){1'b0}}, start_y_reg};
                    pos_reg[2] <= {{(32-START_W){start_z_reg[START_W-1]}}, start_z_reg};
                    for (int i = 0; i < 3; i++)
                    begin
                        vel_reg[i]  <= '0;
                        facc_reg[i] <= '0;
                    end
                end
                default: ;
            endcase
        end
        else if (state_reg == ST_COMMIT)
        begin
            pos_reg  <= merge_pos;
            vel_reg  <= merge_vel;
            hits_reg <= merge_hits;
            for (int i = 0; i < 3; i++)
            begin
                facc_reg[i] <= '0;
            end
        end
    end

    // Item payload, mass and output data, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            force_reg <= force_vec;
            tstep_reg <= time_step;
        end
        if (state_reg == ST_MASS_SQ)
        begin
            sq_reg <= sq_full[43:16];
        end
        if (state_reg == ST_MASS_CUBE)
        begin
            // A cube that truncates to zero gets one LSB of mass
            mass_reg <= (cube_full[49:16] == '0) ? MASS_W'(1) : cube_full[49:16];
        end
        if (state_reg == ST_WRITE && out_free)
        begin
            out_pos_reg  <= pos_reg;
            out_vel_reg  <= vel_reg;
            out_hits_reg <= hits_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_WRITE && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Three axis lanes side by side
    for (genvar g = 0; g < 3; g++)
    begin : g_lane
        sbp_lane u_lane (
            .clk       (clk),
            .ctrl      (lane_ctrl),
            .force_val (force_reg[g]),
            .facc      (facc_reg[g]),
            .vel       (vel_reg[g]),
            .pos       (pos_reg[g]),
            .time_step (tstep_reg),
            .mass      (mass_reg),
            .vel_new   (lane_vel[g]),
            .pos_new   (lane_pos[g])
        );
    end

    sbp_merge u_merge (
        .clk     (clk),
        .ctrl    (merge_ctrl),
        .radius  (radius_reg),
        .pos_in  (lane_pos),
        .vel_in  (lane_vel),
        .pos_out (merge_pos),
        .vel_out (merge_vel),
        .hits    (merge_hits)
    );

    assign out_valid = out_valid_reg;
    assign pos_x     = out_pos_reg[0];
    assign pos_y     = out_pos_reg[1];
    assign pos_z     = out_pos_reg[2];
    assign vel_x     = out_vel_reg[0];
    assign vel_y     = out_vel_reg[1];
    assign vel_z     = out_vel_reg[2];
    assign wall_hits = out_hits_reg;

endmodule

>>> src/sbp_lane.sv
// One axis lane: force-over-mass divider, shared time-step multiplier, velocity and position update.
module sbp_lane (
    input  logic                          clk,
    input  sbp_pkg::lane_ctrl_t           ctrl,
    input  sbp_pkg::word_t                force_val,
    input  sbp_pkg::word_t                facc,
    input  sbp_pkg::word_t                vel,
    input  sbp_pkg::word_t                pos,
    input  logic [sbp_pkg::TSTEP_W-1:0]   time_step,
    input  logic [sbp_pkg::MASS_W-1:0]    mass,
    output sbp_pkg::word_t                vel_new,
    output sbp_pkg::word_t                pos_new
);
    import sbp_pkg::*;

    logic signed [32:0]  sum;
    logic [32:0]         sum_mag;
    logic                ovf;
    logic [MASS_W:0]     trial;
    logic                fits;
    logic [MASS_W-1:0]   rem_next;
    logic [31:0]         acc_mag;
    logic [31:0]         mul_a;
    logic                mul_neg;
    logic [48:0]         mul_full;
    word_t               mulq;

    logic                neg_reg;
    logic                ovf_reg;
    logic [MASS_W-1:0]   rem_reg;
    logic [31:0]         quo_reg;
    logic [32:0]         prod_reg;
    logic                prod_neg_reg;
    word_t               vel_new_reg;
    word_t               pos_new_reg;

    assign sum     = $signed({force_val[31], force_val}) + $signed({facc[31], facc});
    assign sum_mag = sum[32] ? (~sum + 33'd1) : sum;
    // Quotient reaches 2^32: the acceleration saturates either way
    assign ovf     = {17'd0, sum_mag} >= {mass, 16'd0};

    // Restoring divide, one quotient bit per cycle
    assign trial    = {rem_reg, quo_reg[31]};
    assign fits     = trial >= {1'b0, mass};
    assign rem_next = fits ? MASS_W'(trial - {1'b0, mass}) : trial[MASS_W-1:0];

    assign acc_mag = (ovf_reg || quo_reg[31]) ? (neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                              : quo_reg;

    assign mul_a    = ctrl.mul_acc ? acc_mag : abs32(vel_new_reg);
    assign mul_neg  = ctrl.mul_acc ? neg_reg : vel_new_reg[31];
    assign mul_full = {17'd0, mul_a} * {32'd0, time_step};
    assign mulq     = apply_sign(prod_reg, prod_neg_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            neg_reg <= sum[32];
            ovf_reg <= ovf;
            rem_reg <= {{(MASS_W-17){1'b0}}, sum_mag[32:16]};
            quo_reg <= {sum_mag[15:0], 16'd0};
        end
        if (ctrl.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[30:0], fits};
        end
        if (ctrl.mul_acc || ctrl.mul_vel)
        begin
            prod_reg     <= mul_full[48:16];
            prod_neg_reg <= mul_neg;
        end
        if (ctrl.add_vel)
        begin
            vel_new_reg <= add_sat(vel, mulq);
        end
        if (ctrl.add_pos)
        begin
            pos_new_reg <= add_sat(pos, mulq);
        end
    end

    assign vel_new = vel_new_reg;
    assign pos_new = pos_new_reg;

endmodule

>>> src/sbp_merge.sv
// Merge stage: wall bounces over the three lanes' results, with floor damping across axes.
module sbp_merge (
    input  logic                           clk,
    input  sbp_pkg::merge_ctrl_t           ctrl,
    input  logic [sbp_pkg::RADIUS_W-1:0]   radius,
    input  sbp_pkg::word_t                 pos_in  [3],
    input  sbp_pkg::word_t                 vel_in  [3],
    output sbp_pkg::word_t                 pos_out [3],
    output sbp_pkg::word_t                 vel_out [3],
    output logic [5:0]                     hits
);
    import sbp_pkg::*;

    word_t   r_ext;
    word_t   lim_lo [3];
    word_t   lim_hi [3];
    bounce_t bx;
    bounce_t by;
    bounce_t bz;

    word_t      pos_reg [3];
    word_t      vel_reg [3];
    logic [5:0] hits_reg;

    function automatic bounce_t bounce_axis(input word_t p, input word_t v,
                                            input word_t lo, input word_t hi);
        bounce_t b;
        b.pos    = p;
        b.vel    = v;
        b.hit_lo = 1'b0;
        b.hit_hi = 1'b0;
        if ($signed(b.pos) <= $signed(lo) && b.vel[31])
        begin
            b.pos    = lo;
            b.vel    = halve_reverse(b.vel);
            b.hit_lo = 1'b1;
        end
        if ($signed(b.pos) >= $signed(hi) && !b.vel[31] && (b.vel != 32'sd0))
        begin
            b.pos    = hi;
            b.vel    = halve_reverse(b.vel);
            b.hit_hi = 1'b1;
        end
        return b;
    endfunction

    function automatic word_t damp(input word_t v);
        logic [47:0] p;
        p = {16'd0, abs32(v)} * {32'd0, FLOOR_DAMP};
        return apply_sign({1'b0, p[47:16]}, v[31]);
    endfunction

    assign r_ext     = {{(32-RADIUS_W){1'b0}}, radius};
    assign lim_lo[0] = BOX_LO_XZ + r_ext;
    assign lim_hi[0] = BOX_HI_XZ - r_ext;
    assign lim_lo[1] = BOX_LO_Y + r_ext;
    assign lim_hi[1] = BOX_HI_Y - r_ext;
    assign lim_lo[2] = BOX_LO_XZ + r_ext;
    assign lim_hi[2] = BOX_HI_XZ - r_ext;

    always_comb
    begin
        bx = bounce_axis(pos_reg[0], vel_reg[0], lim_lo[0], lim_hi[0]);
        by = bounce_axis(pos_reg[1], vel_reg[1], lim_lo[1], lim_hi[1]);
        bz = bounce_axis(pos_reg[2], vel_reg[2], lim_lo[2], lim_hi[2]);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            pos_reg  <= pos_in;
            vel_reg  <= vel_in;
            hits_reg <= 6'd0;
        end
        if (ctrl.bounce_xy)
        begin
            pos_reg[0]    <= bx.pos;
            vel_reg[0]    <= bx.vel;
            pos_reg[1]    <= by.pos;
            vel_reg[1]    <= by.vel;
            hits_reg[1:0] <= {bx.hit_hi, bx.hit_lo};
            hits_reg[3:2] <= {by.hit_hi, by.hit_lo};
        end
        // Floor hit slows the sliding components
        if (ctrl.damp && hits_reg[2])
        begin
            vel_reg[0] <= damp(vel_reg[0]);
            vel_reg[2] <= damp(vel_reg[2]);
        end
        if (ctrl.bounce_z)
        begin
            pos_reg[2]    <= bz.pos;
            vel_reg[2]    <= bz.vel;
            hits_reg[5:4] <= {bz.hit_hi, bz.hit_lo};
        end
    end

    assign pos_out = pos_reg;
    assign vel_out = vel_reg;
    assign hits    = hits_reg;

endmodule

>>> src/sbp_checker.sv
// Port-level checker for the physics step block and its bind to the top level.
module sbp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] pos_x,
    input logic signed [31:0] pos_y,
    input logic signed [31:0] pos_z,
    input logic signed [31:0] vel_x,
    input logic signed [31:0] vel_y,
    input logic signed [31:0] vel_z,
    input logic [5:0]         wall_hits
);

    // One item in flight: an accepted item blocks the input next cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while an item is in flight");

    // A new result is posted only as the block goes idle
    a_idle_on_post: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result posted while the block stays busy");

    // Back-to-back results only when the next result is posted, leaving the block idle
    a_refill_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid || in_ready)
        else $error("output refilled without the block going idle");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_y)
            && $stable(pos_z) && $stable(vel_x) && $stable(vel_y) && $stable(vel_z)
            && $stable(wall_hits))
        else $error("stalled result changed");

endmodule

bind sphere_box_physics_step sbp_checker u_sbp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .vel_x     (vel_x),
    .vel_y     (vel_y),
    .vel_z     (vel_z),
    .wall_hits (wall_hits)
);
